// ===== src/trr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trr_pkg
// shared types, widths and register codes of the reshape address remap
// ----------------------------------------------------------------------------
package trr_pkg;

  localparam int REG_W   = 13;  // configuration register width
  localparam int CNT_W   = 12;  // coordinate counters
  localparam int PLANE_W = 25;  // product of two dimensions, up to 2**24
  localparam int POS_W   = 37;  // element count or position, up to 2**36
  localparam int VAL_W   = 32;
  localparam int ADDR_W  = 24;
  localparam int IDX_W   = 3;
  localparam int DIM_MAX = 4096;

  localparam longint unsigned MAX_ELEMENTS_DEF = 64'd16777216;

  localparam logic [IDX_W-1:0] REG_SOURCE_ROWS     = 3'd0;
  localparam logic [IDX_W-1:0] REG_SOURCE_COLS     = 3'd1;
  localparam logic [IDX_W-1:0] REG_SOURCE_CHANNELS = 3'd2;
  localparam logic [IDX_W-1:0] REG_TARGET_ROWS     = 3'd3;
  localparam logic [IDX_W-1:0] REG_TARGET_COLS     = 3'd4;
  localparam logic [IDX_W-1:0] REG_TARGET_CHANNELS = 3'd5;

  // effective shape, out-of-range dimensions already replaced by 1
  typedef struct packed {
    logic [REG_W-1:0] sr;
    logic [REG_W-1:0] sc;
    logic [REG_W-1:0] sch;
    logic [REG_W-1:0] tr;
    logic [REG_W-1:0] tc;
    logic [REG_W-1:0] tch;
    logic             regs_ok;
  } trr_shape_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [PLANE_W-1:0] dplane;
    logic [VAL_W-1:0]   value;
    logic               last;
    logic               err;
  } trr_entry_t;

endpackage

// ===== src/trr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trr_queue
// two-entry queue between the front and back of the remap
// ----------------------------------------------------------------------------
module trr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  trr_pkg::trr_entry_t wr_entry,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output trr_pkg::trr_entry_t rd_entry
);
  import trr_pkg::*;

  trr_entry_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign rd_entry  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (pop && not_empty) rd_ptr <= ~rd_ptr;
      case ({push && !full, pop && not_empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/trr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trr_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module trr_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [trr_pkg::POS_W-1:0]   numer,
  input  logic [trr_pkg::PLANE_W-1:0] denom,
  output logic                        done,
  output logic [trr_pkg::POS_W-1:0]   quot,
  output logic [trr_pkg::PLANE_W-1:0] rem
);
  import trr_pkg::*;

  localparam int CW = $clog2(POS_W);

  logic [PLANE_W-1:0] den_r;
  logic [CW-1:0]      cnt;
  logic               busy;
  logic [PLANE_W:0]   shifted;
  logic               ge;

  assign shifted = {rem, quot[POS_W-1]};
  assign ge      = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= denom;
      quot  <= numer;
      rem   <= '0;
    end else if (busy) begin
      rem  <= ge ? PLANE_W'(shifted - {1'b0, den_r}) : shifted[PLANE_W-1:0];
      quot <= {quot[POS_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CW'(1);
      if (cnt == CW'(POS_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

// ===== src/trr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trr_front
// takes items, tracks the source coordinate, forms position and error flag
// ----------------------------------------------------------------------------
module trr_front #(
  parameter longint unsigned MAX_ELEMENTS = trr_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  trr_pkg::trr_shape_t       shape,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [trr_pkg::VAL_W-1:0] in_value,
  output logic                      push,
  output trr_pkg::trr_entry_t       entry,
  input  logic                      q_full
);
  import trr_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL1 = 2'd1;
  localparam logic [1:0] F_MUL2 = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]         st;
  logic [CNT_W-1:0]   row, col, chn;
  logic [CNT_W-1:0]   r_l, c_l, ch_l;
  logic [VAL_W-1:0]   value;
  logic               last;
  logic [PLANE_W-1:0] plane_s, dplane, rc;
  logic [POS_W-1:0]   pos_hi, src_total, dst_total, pos;
  logic               row_end, col_end, ch_end, err;

  assign row_end = ({1'b0, row} + REG_W'(1)) >= shape.sr;
  assign col_end = ({1'b0, col} + REG_W'(1)) >= shape.sc;
  assign ch_end  = ({1'b0, chn} + REG_W'(1)) >= shape.sch;

  assign in_ready = (st == F_IDLE);
  assign pos      = pos_hi + {{(POS_W-PLANE_W){1'b0}}, rc} + {{(POS_W-CNT_W){1'b0}}, c_l};
  assign err      = !shape.regs_ok || (src_total != dst_total) ||
                    ({{(64-POS_W){1'b0}}, src_total} > MAX_ELEMENTS) || (pos >= src_total);
  assign push     = (st == F_PUSH) && !q_full;
  assign entry    = '{pos: pos, dplane: dplane, value: value, last: last, err: err};

  always_ff @(posedge clk) begin
    unique case (st)
      F_IDLE: begin
        value <= in_value;
        r_l   <= row;
        c_l   <= col;
        ch_l  <= chn;
        last  <= row_end && col_end && ch_end;
      end
      F_MUL1: begin
        plane_s <= PLANE_W'({{(PLANE_W-REG_W){1'b0}}, shape.sr} *
                            {{(PLANE_W-REG_W){1'b0}}, shape.sc});
        dplane  <= PLANE_W'({{(PLANE_W-REG_W){1'b0}}, shape.tr} *
                            {{(PLANE_W-REG_W){1'b0}}, shape.tc});
        rc      <= PLANE_W'({{(PLANE_W-CNT_W){1'b0}}, r_l} *
                            {{(PLANE_W-REG_W){1'b0}}, shape.sc});
      end
      F_MUL2: begin
        pos_hi    <= {{(POS_W-CNT_W){1'b0}}, ch_l} * {{(POS_W-PLANE_W){1'b0}}, plane_s};
        src_total <= {{(POS_W-PLANE_W){1'b0}}, plane_s} * {{(POS_W-REG_W){1'b0}}, shape.sch};
        dst_total <= {{(POS_W-PLANE_W){1'b0}}, dplane} * {{(POS_W-REG_W){1'b0}}, shape.tch};
      end
      F_PUSH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= F_IDLE;
      row <= '0;
      col <= '0;
      chn <= '0;
    end else begin
      unique case (st)
        F_IDLE: begin
          if (in_valid) begin
            st <= F_MUL1;
            if (!row_end) begin
              row <= row + CNT_W'(1);
            end else begin
              row <= '0;
              if (!col_end) begin
                col <= col + CNT_W'(1);
              end else begin
                col <= '0;
                chn <= ch_end ? '0 : chn + CNT_W'(1);
              end
            end
          end
        end
        F_MUL1:  st <= F_MUL2;
        F_MUL2:  st <= F_PUSH;
        F_PUSH:  if (!q_full) st <= F_IDLE;
        default: st <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== src/trr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trr_back
// splits position into destination coordinates and address, holds result
// ----------------------------------------------------------------------------
module trr_back (
  input  logic                clk,
  input  logic                rst,
  input  trr_pkg::trr_shape_t shape,
  input  logic                q_valid,
  input  trr_pkg::trr_entry_t q_entry,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [95:0]         out_data,
  output logic                out_last,
  output logic                out_err
);
  import trr_pkg::*;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_DIV1 = 3'd1;
  localparam logic [2:0] B_DIV2 = 3'd2;
  localparam logic [2:0] B_MUL  = 3'd3;
  localparam logic [2:0] B_SUM  = 3'd4;
  localparam logic [2:0] B_DONE = 3'd5;

  logic [2:0]         st;
  logic [PLANE_W-1:0] plane;
  logic [VAL_W-1:0]   value;
  logic               last, err;
  logic [CNT_W-1:0]   dch, drow, dcol;
  logic [ADDR_W-1:0]  p1, p2, addr;

  logic               div_start, div_done;
  logic [POS_W-1:0]   div_numer, div_quot;
  logic [PLANE_W-1:0] div_denom, div_rem;

  assign pop       = (st == B_IDLE) && q_valid;
  assign div_start = (pop && !q_entry.err) || ((st == B_DIV1) && div_done);
  assign div_numer = (st == B_IDLE) ? q_entry.pos : {{(POS_W-PLANE_W){1'b0}}, div_rem};
  assign div_denom = (st == B_IDLE) ? q_entry.dplane
                                    : {{(PLANE_W-REG_W){1'b0}}, shape.tc};

  trr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    unique case (st)
      B_IDLE: begin
        plane <= q_entry.dplane;
        value <= q_entry.value;
        last  <= q_entry.last;
        err   <= q_entry.err;
        dch   <= '0;
        drow  <= '0;
        dcol  <= '0;
        addr  <= '0;
      end
      B_DIV1: if (div_done) dch <= div_quot[CNT_W-1:0];
      B_DIV2: begin
        if (div_done) begin
          drow <= div_quot[CNT_W-1:0];
          dcol <= div_rem[CNT_W-1:0];
        end
      end
      B_MUL: begin
        p1 <= ADDR_W'({{(PLANE_W-CNT_W){1'b0}}, dch} * plane);
        p2 <= ADDR_W'({{(PLANE_W-CNT_W){1'b0}}, dcol} *
                      {{(PLANE_W-REG_W){1'b0}}, shape.tr});
      end
      B_SUM:  addr <= p1 + p2 + {{(ADDR_W-CNT_W){1'b0}}, drow};
      B_DONE: begin
        if (!out_valid || out_ready) begin
          out_data <= {4'd0, value, addr, dcol, drow, dch};
          out_last <= last;
          out_err  <= err;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((st == B_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        B_IDLE: if (q_valid) st <= q_entry.err ? B_DONE : B_DIV1;
        B_DIV1: if (div_done) st <= B_DIV2;
        B_DIV2: if (div_done) st <= B_MUL;
        B_MUL:  st <= B_SUM;
        B_SUM:  st <= B_DONE;
        B_DONE: if (!out_valid || out_ready) st <= B_IDLE;
        default: st <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== src/tensor_reshape_address_remap.sv =====
`timescale 1ns / 1ps
// path from input item to result item: front states MUL1, MUL2, PUSH, the queue, two
//   divider passes, then MUL, SUM, DONE; shape error items go straight to DONE
// the shared bit-serial divider limits the item rate: the back takes one item
//   at a time, two divider passes each; error items skip it, paced by the front
// the front runs ahead by up to three items: two in the queue and one held
// reset: synchronous, clears counters, queue and handshakes; config registers to 1
// ----------------------------------------------------------------------------
// tensor_reshape_address_remap
// remaps source-order tensor elements to destination coordinates and address
// ----------------------------------------------------------------------------
module tensor_reshape_address_remap #(
  parameter longint unsigned MAX_ELEMENTS = trr_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration write port
  input  logic                      cfg_we,
  input  logic [trr_pkg::IDX_W-1:0] cfg_index,
  input  logic [trr_pkg::REG_W-1:0] cfg_data,
  // input items
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [31:0]               s_tdata,   // element_value
  // result items
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // dest_channel, dest_row, dest_col, dest_address, out_value, 4 zero bits
  output logic [95:0]               m_tdata,
  output logic                      m_tlast,   // last_element
  output logic                      m_tuser    // shape_error
);
  import trr_pkg::*;

  // configuration registers, raw as written
  logic [REG_W-1:0] source_rows, source_cols, source_channels;
  logic [REG_W-1:0] dest_rows, dest_cols, dest_channels;

  trr_shape_t shape;
  trr_entry_t f_entry, q_entry;
  logic       f_push, q_full, q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_rows     <= REG_W'(1);
      source_cols     <= REG_W'(1);
      source_channels <= REG_W'(1);
      dest_rows       <= REG_W'(1);
      dest_cols       <= REG_W'(1);
      dest_channels   <= REG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_ROWS:     source_rows     <= cfg_data;
        REG_SOURCE_COLS:     source_cols     <= cfg_data;
        REG_SOURCE_CHANNELS: source_channels <= cfg_data;
        REG_TARGET_ROWS:     dest_rows       <= cfg_data;
        REG_TARGET_COLS:     dest_cols       <= cfg_data;
        REG_TARGET_CHANNELS: dest_channels   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // a dimension is usable in 1..4096; otherwise it counts as 1 and flags an error
  function automatic logic dim_ok(input logic [REG_W-1:0] d);
    return (d != '0) && (d <= REG_W'(DIM_MAX));
  endfunction

  function automatic logic [REG_W-1:0] dim_eff(input logic [REG_W-1:0] d);
    return dim_ok(d) ? d : REG_W'(1);
  endfunction

  always_comb begin
    shape.sr      = dim_eff(source_rows);
    shape.sc      = dim_eff(source_cols);
    shape.sch     = dim_eff(source_channels);
    shape.tr      = dim_eff(dest_rows);
    shape.tc      = dim_eff(dest_cols);
    shape.tch     = dim_eff(dest_channels);
    shape.regs_ok = dim_ok(source_rows) && dim_ok(source_cols) &&
                    dim_ok(source_channels) && dim_ok(dest_rows) &&
                    dim_ok(dest_cols) && dim_ok(dest_channels);
  end

  // front: counters, linear position and error classification
  trr_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .shape    (shape),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_value (s_tdata),
    .push     (f_push),
    .entry    (f_entry),
    .q_full   (q_full)
  );

  // decouples the two halves
  trr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .wr_entry  (f_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rd_entry  (q_entry)
  );

  // back: divisions, address and output register
  trr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .shape     (shape),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .pop       (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast),
    .out_err   (m_tuser)
  );

  // an error result carries zero coordinates and address
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[59:0] == 60'd0)
    else $error("error result with nonzero coordinates");

  // a good result lands inside the destination shape
  a_dest_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> ({1'b0, m_tdata[11:0]} < shape.tch) &&
      ({1'b0, m_tdata[23:12]} < shape.tr) && ({1'b0, m_tdata[35:24]} < shape.tc))
    else $error("destination coordinate out of range");

  // the front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    f_push |-> !q_full)
    else $error("queue overflow");

endmodule
